// ===== sv/signed_radix_to_ascii_core_defines.svh =====
// Assertion macros shared by the checker of the radix-to-ASCII converter.
// Depends on nothing; included by the checker file only.
`ifndef SIGNED_RADIX_TO_ASCII_CORE_DEFINES_SVH
`define SIGNED_RADIX_TO_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SRA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sra_pkg.sv =====
// Types, constants and helper functions of the radix-to-ASCII converter.
// Depends on nothing; used by the divider, the top level and the testbench.
package sra_pkg;

  localparam int unsigned MaxDigits = 32;
  localparam int unsigned DigitW    = 6;
  localparam int unsigned CountW    = 6;

  localparam logic [5:0] RadixMin   = 6'd2;
  localparam logic [5:0] RadixMax   = 6'd36;
  localparam logic [5:0] RadixReset = 6'd10;

  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharZero  = 8'h30;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [5:0]  radix;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [5:0]  rem;
  } div_rsp_t;

  // Floor of 2^32 divided by the radix, for radix 2 to 36.
  function automatic logic [31:0] recip(input logic [5:0] radix);
    logic [31:0] m;
    case (radix)
      6'd2:    m = 32'h8000_0000;
      6'd3:    m = 32'h5555_5555;
      6'd4:    m = 32'h4000_0000;
      6'd5:    m = 32'h3333_3333;
      6'd6:    m = 32'h2aaa_aaaa;
      6'd7:    m = 32'h2492_4924;
      6'd8:    m = 32'h2000_0000;
      6'd9:    m = 32'h1c71_c71c;
      6'd10:   m = 32'h1999_9999;
      6'd11:   m = 32'h1745_d174;
      6'd12:   m = 32'h1555_5555;
      6'd13:   m = 32'h13b1_3b13;
      6'd14:   m = 32'h1249_2492;
      6'd15:   m = 32'h1111_1111;
      6'd16:   m = 32'h1000_0000;
      6'd17:   m = 32'h0f0f_0f0f;
      6'd18:   m = 32'h0e38_e38e;
      6'd19:   m = 32'h0d79_435e;
      6'd20:   m = 32'h0ccc_cccc;
      6'd21:   m = 32'h0c30_c30c;
      6'd22:   m = 32'h0ba2_e8ba;
      6'd23:   m = 32'h0b21_642c;
      6'd24:   m = 32'h0aaa_aaaa;
      6'd25:   m = 32'h0a3d_70a3;
      6'd26:   m = 32'h09d8_9d89;
      6'd27:   m = 32'h097b_425e;
      6'd28:   m = 32'h0924_9249;
      6'd29:   m = 32'h08d3_dcb0;
      6'd30:   m = 32'h0888_8888;
      6'd31:   m = 32'h0842_1084;
      6'd32:   m = 32'h0800_0000;
      6'd33:   m = 32'h07c1_f07c;
      6'd34:   m = 32'h0787_8787;
      6'd35:   m = 32'h0750_7507;
      6'd36:   m = 32'h071c_71c7;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

  // ASCII glyph of one digit value: 0-9 and then lowercase a-z.
  function automatic logic [7:0] glyph(input logic [5:0] d);
    logic [7:0] c;
    if (d < 6'd10) begin
      c = CharZero + 8'(d);
    end else if (d < RadixMax) begin
      c = 8'(d) + 8'h57;
    end else begin
      c = CharZero;
    end
    return c;
  endfunction

endpackage

// ===== sv/sra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sra_ram #(
  parameter int unsigned Width = 6,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sra_divider.sv =====
// Shared divider: divides one 32-bit magnitude by the radix and takes the next request as it finishes.
// A reciprocal multiply gives a quotient at most one low, then one correction step.
// Depends on sra_pkg for the request and response types and the reciprocal table.
module sra_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sra_pkg::div_req_t req_i,
  output sra_pkg::div_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_MUL,
    D_FIX
  } div_state_e;

  div_state_e  state_q, state_d;
  logic [31:0] x_q, x_d;
  logic [5:0]  b_q, b_d;
  logic [31:0] m_q, m_d;
  logic [31:0] qe_q, qe_d;

  logic [63:0] prod;
  logic [6:0]  r7;
  logic        fix;
  logic        can_start;

  assign prod = 64'(x_q) * 64'(m_q);
  assign r7   = x_q[6:0] - (qe_q[6:0] * {1'b0, b_q});
  assign fix  = (r7 >= {1'b0, b_q});

  assign can_start = (state_q == D_IDLE) || (state_q == D_FIX);

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    b_d     = b_q;
    m_d     = m_q;
    qe_d    = qe_q;
    case (state_q)
      D_MUL: begin
        qe_d    = prod[63:32];
        state_d = D_FIX;
      end
      D_FIX: begin
        state_d = D_IDLE;
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
    if (can_start && req_i.start) begin
      x_d     = req_i.dividend;
      b_d     = req_i.radix;
      m_d     = sra_pkg::recip(req_i.radix);
      state_d = D_MUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    b_q  <= b_d;
    m_q  <= m_d;
    qe_q <= qe_d;
  end

  assign rsp_o.done = (state_q == D_FIX);
  assign rsp_o.quot = qe_q + {31'd0, fix};
  assign rsp_o.rem  = fix ? 6'(r7 - {1'b0, b_q}) : r7[5:0];

endmodule

// ===== sv/signed_radix_to_ascii_core.sv =====
// Top level of the radix-to-ASCII converter; depends on sra_pkg, sra_divider and sra_ram.
// Sequencing: the shared divider gives one digit per request, least significant first, into the
// digit RAM; the characters are then read back most significant first, after a minus sign if any.
// Throughput: one item at a time; the next input is taken only after the last character of an item
// is taken (the minus sign overlaps the first RAM read); an invalid radix gives one NUL flagged last.
// Reset: radix becomes 10 and the sequencer idles; the digit RAM is not cleared.
module signed_radix_to_ascii_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  character_o,
  output logic        last_char_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_RD,
    S_OUT,
    S_ERR
  } core_state_e;

  core_state_e state_q;
  logic [5:0]  radix_q;
  logic [5:0]  cnt_q;
  logic        neg_q;
  logic [7:0]  char_q;

  sra_pkg::div_req_t div_req;
  sra_pkg::div_rsp_t div_rsp;

  logic        radix_ok;
  logic        in_fire;
  logic        out_fire;
  logic [31:0] magnitude;
  logic        more_digits;
  logic [5:0]  cnt_m1;
  logic [5:0]  cnt_m2;
  logic        ram_we;
  logic        ram_re;
  logic [4:0]  ram_raddr;
  logic [5:0]  ram_rdata;

  assign cfg_ready_o = 1'b1;

  assign radix_ok  = (radix_q >= sra_pkg::RadixMin) && (radix_q <= sra_pkg::RadixMax);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_SIGN) || (state_q == S_OUT) || (state_q == S_ERR);
  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fire  = out_valid_o && out_ready_i;
  assign magnitude = number_i[31] ? (32'd0 - number_i) : number_i;
  assign more_digits = (div_rsp.quot != 32'd0) && (cnt_q != 6'(sra_pkg::MaxDigits - 1));
  assign cnt_m1 = cnt_q - 6'd1;
  assign cnt_m2 = cnt_q - 6'd2;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = div_rsp.quot;
    div_req.radix    = radix_q;
    if (state_q == S_IDLE) begin
      div_req.start    = in_fire && radix_ok;
      div_req.dividend = magnitude;
    end else if (state_q == S_DIV) begin
      div_req.start = div_rsp.done && more_digits;
    end
  end

  assign ram_we = (state_q == S_DIV) && div_rsp.done;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cnt_m1[4:0];
    case (state_q)
      S_RD: begin
        ram_re = 1'b1;
      end
      S_SIGN: begin
        ram_re = out_ready_i;
      end
      S_OUT: begin
        ram_re    = out_ready_i && (cnt_q != 6'd1);
        ram_raddr = cnt_m2[4:0];
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  sra_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sra_ram #(
    .Width (sra_pkg::DigitW),
    .Depth (sra_pkg::MaxDigits)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[4:0]),
    .wdata_i (div_rsp.rem),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      radix_q <= sra_pkg::RadixReset;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      char_q  <= sra_pkg::CharNul;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        radix_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cnt_q <= '0;
            neg_q <= number_i[31];
            if (radix_ok) begin
              state_q <= S_DIV;
            end else begin
              char_q  <= sra_pkg::CharNul;
              state_q <= S_ERR;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            cnt_q <= cnt_q + 6'd1;
            if (!more_digits) begin
              if (neg_q) begin
                char_q  <= sra_pkg::CharMinus;
                state_q <= S_SIGN;
              end else begin
                state_q <= S_RD;
              end
            end
          end
        end
        S_SIGN: begin
          if (out_ready_i) begin
            state_q <= S_OUT;
          end
        end
        S_RD: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            cnt_q <= cnt_m1;
            if (cnt_q == 6'd1) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_ERR: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign character_o = (state_q == S_OUT) ? sra_pkg::glyph(ram_rdata) : char_q;
  assign last_char_o = (state_q == S_ERR) || ((state_q == S_OUT) && (cnt_q == 6'd1));

endmodule

// ===== sv/sra_checker.sv =====
// Port-level checker for the radix-to-ASCII converter, bound to the top level.
// Depends on signed_radix_to_ascii_core_defines.svh for the assertion macros.
`include "signed_radix_to_ascii_core_defines.svh"

module sra_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] character_o,
  input logic       last_char_o
);

  // A stalled output transaction holds its character and flag.
  `SRA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(character_o) && $stable(last_char_o),
                   "output changed while stalled")

  // No new input is taken while characters are still pending.
  `SRA_ASSERT_SAME(a_busy_no_ready, clk_i, rst_ni, out_valid_o, !in_ready_o,
                   "input ready while output pending")

  // An accepted input always produces at least one character first.
  `SRA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o,
                   "input ready right after a transaction")

  // The empty-text marker is always the last character of its number.
  `SRA_ASSERT_SAME(a_nul_last, clk_i, rst_ni, out_valid_o && (character_o == 8'h00),
                   last_char_o, "NUL not flagged last")

  // After the last character is taken the block is ready again.
  `SRA_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, out_valid_o && out_ready_i && last_char_o,
                   in_ready_o && !out_valid_o, "not idle after last character")

endmodule

bind signed_radix_to_ascii_core sra_checker u_sra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .character_o (character_o),
  .last_char_o (last_char_o)
);

// ===== tb/testbench.sv =====
// Self-checking testbench of signed_radix_to_ascii_core: directed and random numbers under
// many radix settings, with random idling on both handshakes and a golden ASCII predictor.
// Depends on sra_pkg and the core RTL only.
module testbench;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  typedef enum logic [1:0] {
    BY_PREDICTOR,
    BY_TEXT,
    BY_EMPTY
  } check_kind_e;

  localparam logic [7:0] CharLowerA = "a";
  localparam int unsigned NumPhases = 15;
  localparam int unsigned PhaseItems = 24;
  localparam logic [5:0] PhaseRadix [10] = '{6'd2, 6'd36, 6'd0, 6'd16, 6'd63,
                                            6'd35, 6'd1, 6'd37, 6'd3, 6'd10};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [5:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] number_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  character_o;
  logic        last_char_o;

  char_beat_t  pending_chars[$];
  logic [5:0]  radix_now = sra_pkg::RadixReset;
  bit          quiet_phase = 1'b0;
  int unsigned rx_hold_cycles = 0;
  int unsigned numbers_done = 0;
  int unsigned empty_numbers = 0;
  int unsigned radix_writes = 0;
  int unsigned chars_seen = 0;
  int unsigned mismatches = 0;

  logic [5:0]  row_radix[$];
  logic [31:0] row_number[$];
  check_kind_e row_kind[$];
  string       row_text[$];

  signed_radix_to_ascii_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .number_i    (number_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #15_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 30) begin
      $display("Mismatch at %0t on %s: got 0x%0h, expected 0x%0h (character %0d).",
               $time, what, got, want, chars_seen);
    end
    mismatches++;
  endtask

  function automatic void expect_char(input logic [7:0] ch, input logic last);
    char_beat_t beat;
    beat.ch = ch;
    beat.last = last;
    pending_chars.push_back(beat);
  endfunction

  function automatic void predict_ascii(input logic [5:0] base, input logic [31:0] value);
    logic [31:0] magnitude;
    logic [31:0] digit;
    logic [7:0]  glyphs[$];
    if (base < sra_pkg::RadixMin || base > sra_pkg::RadixMax) begin
      expect_char(sra_pkg::CharNul, 1'b1);
      return;
    end
    magnitude = value[31] ? (32'd0 - value) : value;
    do begin
      digit = magnitude % {26'd0, base};
      glyphs.push_front(digit < 32'd10 ? sra_pkg::CharZero + digit[7:0]
                                       : CharLowerA + digit[7:0] - 8'd10);
      magnitude = magnitude / {26'd0, base};
    end while (magnitude != 32'd0);
    if (value[31]) begin
      expect_char(sra_pkg::CharMinus, 1'b0);
    end
    foreach (glyphs[k]) begin
      expect_char(glyphs[k], k == glyphs.size() - 1);
    end
  endfunction

  task automatic add_row(input logic [5:0] radix, input logic [31:0] value,
                         input check_kind_e kind, input string text);
    row_radix.push_back(radix);
    row_number.push_back(value);
    row_kind.push_back(kind);
    row_text.push_back(text);
  endtask

  task automatic write_radix(input logic [5:0] value);
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    radix_now = value;
    radix_writes++;
  endtask

  task automatic send_number(input logic [31:0] value, input check_kind_e kind,
                             input string text);
    in_valid_i <= 1'b1;
    number_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    case (kind)
      BY_PREDICTOR: predict_ascii(radix_now, value);
      BY_EMPTY: expect_char(sra_pkg::CharNul, 1'b1);
      default: begin
        for (int k = 0; k < text.len(); k++) begin
          expect_char(text[k], k == text.len() - 1);
        end
      end
    endcase
    numbers_done++;
    if (radix_now < sra_pkg::RadixMin || radix_now > sra_pkg::RadixMax) begin
      empty_numbers++;
    end
  endtask

  task automatic sender_gap(input bit quiet);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : char_check
    char_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("character with none expected", {24'd0, character_o}, 32'd0);
      end else begin
        want = pending_chars.pop_front();
        if (character_o !== want.ch) begin
          report_mismatch("character", {24'd0, character_o}, {24'd0, want.ch});
        end
        if (last_char_o !== want.last) begin
          report_mismatch("last_char", {31'd0, last_char_o}, {31'd0, want.last});
        end
      end
      chars_seen++;
    end
  end

  initial begin : char_sink
    int unsigned gap;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles != 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = quiet_phase ? 0 : $urandom_range(0, 14);
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    logic [31:0] value;
    logic [5:0]  next_radix;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= sra_pkg::RadixReset;
    in_valid_i <= 1'b0;
    number_i <= 32'd0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(6'd10, 32'd0, BY_TEXT, "0");
    add_row(6'd10, 32'h7fff_ffff, BY_TEXT, "2147483647");
    add_row(6'd10, 32'h8000_0000, BY_TEXT, "-2147483648");
    add_row(6'd10, 32'hffff_ffff, BY_TEXT, "-1");
    add_row(6'd10, 32'd9, BY_TEXT, "9");
    add_row(6'd10, 32'd10, BY_TEXT, "10");
    add_row(6'd10, 32'd12345, BY_PREDICTOR, "");
    add_row(6'd2, 32'h8000_0000, BY_PREDICTOR, "");
    add_row(6'd2, 32'h7fff_ffff, BY_PREDICTOR, "");
    add_row(6'd2, 32'd0, BY_TEXT, "0");
    add_row(6'd2, 32'd5, BY_TEXT, "101");
    add_row(6'd2, 32'h5555_5555, BY_PREDICTOR, "");
    add_row(6'd8, 32'h8000_0000, BY_TEXT, "-20000000000");
    add_row(6'd16, 32'h7fff_ffff, BY_TEXT, "7fffffff");
    add_row(6'd16, 32'hdead_beef, BY_PREDICTOR, "");
    add_row(6'd36, 32'h7fff_ffff, BY_TEXT, "zik0zj");
    add_row(6'd36, 32'd35, BY_TEXT, "z");
    add_row(6'd36, 32'h8000_0000, BY_PREDICTOR, "");
    add_row(6'd35, 32'hffff_ffde, BY_TEXT, "-y");
    add_row(6'd3, 32'h1234_5678, BY_PREDICTOR, "");
    add_row(6'd0, 32'd5, BY_EMPTY, "");
    add_row(6'd1, 32'h8000_0000, BY_EMPTY, "");
    add_row(6'd37, 32'd0, BY_EMPTY, "");
    add_row(6'd63, 32'hffff_ffff, BY_EMPTY, "");

    foreach (row_number[r]) begin
      if (row_radix[r] != radix_now) begin
        write_radix(row_radix[r]);
      end
      send_number(row_number[r], row_kind[r], row_text[r]);
      sender_gap(1'b0);
    end

    for (int p = 0; p < NumPhases; p++) begin
      quiet_phase = (p % 3 == 1) || (p == 3);
      if (p < 10) begin
        next_radix = PhaseRadix[p];
      end else if ($urandom_range(0, 4) == 0) begin
        next_radix = 6'($urandom_range(0, 63));
      end else begin
        next_radix = 6'($urandom_range(2, 36));
      end
      if (next_radix != radix_now) begin
        write_radix(next_radix);
      end
      if (p == 3) begin
        rx_hold_cycles = 400;
      end
      for (int k = 0; k < PhaseItems; k++) begin
        case ($urandom_range(0, 7))
          0, 1, 2: value = $urandom;
          3: value = $urandom_range(0, 3 * radix_now);
          4: value = 32'd0 - 32'($urandom_range(1, 1000));
          5: begin
            case ($urandom_range(0, 3))
              0: value = 32'h8000_0000;
              1: value = 32'h7fff_ffff;
              2: value = 32'hffff_ffff;
              default: value = 32'd0;
            endcase
          end
          6: begin
            value = 32'd1 << $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1) begin
              value = 32'd0 - value;
            end
          end
          default: value = $urandom >> $urandom_range(0, 31);
        endcase
        send_number(value, BY_PREDICTOR, "");
        if (p == 5 && k == 12) begin
          in_valid_i <= 1'b0;
          while (pending_chars.size() != 0) @(posedge clk_i);
        end else begin
          sender_gap(quiet_phase);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Converted %0d numbers after %0d radix writes, %0d under an invalid radix.",
             numbers_done, radix_writes, empty_numbers);
    $display("Checked %0d characters with random stalls, a long output hold-off and a drain.",
             chars_seen);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
